FILE: design/assert_macros.svh
// Assertion macros shared by the evaluator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define GFH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is asserted
`define GFH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`endif

FILE: design/gfh_pkg.sv
// Shared constants and types of the GF(2^k) Horner evaluator.
package gfh_pkg;

	// width of the field element ports
	localparam int DATA_W = 32;

	// default field size
	localparam int FIELD_BITS_DEF = 32;

	// configuration address width, one 32-bit register per word
	localparam int ADDR_W = 3;

	// reset value of the modulus: x^32 + x^7 + x^3 + x^2 + 1
	localparam logic [DATA_W-1:0] MODULUS_RESET = 32'd141;

	// register indexes
	typedef enum logic [0:0] {
		REG_MODULUS_LOW = 1'b0
	} gfh_reg_t;

endpackage

FILE: design/gfh_if.sv
// Stream interfaces for coefficient items and result items.
interface gfh_in_if;
	logic                        valid;
	logic                        ready;
	logic [gfh_pkg::DATA_W-1:0]  point;
	logic [gfh_pkg::DATA_W-1:0]  coefficient;
	logic                        first_coef;
	logic                        last_coef;

	modport source (output valid, output point, output coefficient,
		output first_coef, output last_coef, input ready);
	modport sink (input valid, input point, input coefficient,
		input first_coef, input last_coef, output ready);
endinterface

interface gfh_out_if;
	logic                        valid;
	logic                        ready;
	logic [gfh_pkg::DATA_W-1:0]  value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

FILE: design/gf2k_horner_polynomial_evaluator_core.sv
// Horner evaluator over GF(2^k), highest degree first. An item enters an input register;
// when it leaves, the multiply by the point, reduction and coefficient XOR update the
// accumulator, and a last item loads its result into the output register. Items are taken
// back to back at one per cycle unless a held result or a table rebuild stalls the input.
// The loop that sets the clock is accumulator -> carry-less multiply -> table
// reduction -> XOR. After reset and after every write of the modulus register the reduction
// table is rebuilt, one entry per cycle; item.ready stays low while that happens.
`include "assert_macros.svh"

module gf2k_horner_polynomial_evaluator_core #(
	parameter int FIELD_BITS = gfh_pkg::FIELD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [gfh_pkg::ADDR_W-1:0]   paddr,
	input  logic [gfh_pkg::DATA_W-1:0]   pwdata,
	output logic [gfh_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	gfh_in_if.sink                       item,
	gfh_out_if.source                    result
);

	localparam int FB    = FIELD_BITS;
	localparam int DW    = gfh_pkg::DATA_W;
	localparam int WIDE  = (FB > DW) ? FB : DW;
	localparam int TAB_D = FB - 1;

	gfh_pkg::gfh_reg_t reg_idx;
	logic              cfg_wr;
	logic [DW-1:0]     modulus_q;
	logic              start_q;
	logic              tab_busy;
	logic [FB-1:0]     tbl [TAB_D];
	logic [WIDE-1:0]   low_wide;
	logic [FB-1:0]     low_m;

	logic [WIDE-1:0]   point_wide;
	logic [WIDE-1:0]   coef_wide;
	logic              valid_s1;
	logic [FB-1:0]     point_s1;
	logic [FB-1:0]     coef_s1;
	logic              first_s1;
	logic              last_s1;
	logic              s1_go;
	logic              accept;

	logic [FB-1:0]     acc_q;
	logic [FB-1:0]     acc_in;
	logic [FB-1:0]     prod_red;
	logic [FB-1:0]     acc_next;
	logic [WIDE-1:0]   acc_wide;
	logic              result_valid_q;
	logic [DW-1:0]     value_q;

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = gfh_pkg::gfh_reg_t'(paddr[gfh_pkg::ADDR_W-1]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_comb begin
		unique case (reg_idx)
			gfh_pkg::REG_MODULUS_LOW: prdata = modulus_q;
			default:                  prdata = '0;
		endcase
	end

	// hold the modulus and request a table rebuild on each modulus write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= gfh_pkg::MODULUS_RESET;
			start_q   <= 1'b1;
		end else begin
			start_q <= 1'b0;
			if (cfg_wr && reg_idx == gfh_pkg::REG_MODULUS_LOW) begin
				modulus_q <= pwdata;
				start_q   <= 1'b1;
			end
		end
	end

	assign low_wide = WIDE'(modulus_q);
	assign low_m    = low_wide[FB-1:0];

	gfh_redtab #(
		.FIELD_BITS (FB)
	) u_redtab (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.low    (low_m),
		.busy   (tab_busy),
		.tbl    (tbl)
	);

	// input register
	assign s1_go     = valid_s1 & (~last_s1 | ~result_valid_q | result.ready);
	assign item.ready = ~tab_busy & (~valid_s1 | s1_go);
	assign accept    = item.valid & item.ready;

	assign point_wide = WIDE'(item.point);
	assign coef_wide  = WIDE'(item.coefficient);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			point_s1 <= point_wide[FB-1:0];
			coef_s1  <= coef_wide[FB-1:0];
			first_s1 <= item.first_coef;
			last_s1  <= item.last_coef;
		end
	end

	// Horner step: acc * point mod m, then add the coefficient
	assign acc_in = first_s1 ? '0 : acc_q;

	gfh_mulred #(
		.FIELD_BITS (FB)
	) u_mulred (
		.a   (acc_in),
		.b   (point_s1),
		.tbl (tbl),
		.r   (prod_red)
	);

	assign acc_next = prod_red ^ coef_s1;
	assign acc_wide = WIDE'(acc_next);

	// advance the accumulator and load a result on the last item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (s1_go) begin
				acc_q <= acc_next;
			end
			if (s1_go && last_s1) begin
				result_valid_q <= 1'b1;
			end else if (result.ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			value_q <= acc_wide[DW-1:0];
		end
	end

	assign result.valid = result_valid_q;
	assign result.value = value_q;

	// a new result comes only from a last item leaving the input register
	`GFH_ASSERT_NOW(a_result_from_last, clk, arst_n,
		result.valid && !$past(result.valid), $past(valid_s1 && last_s1 && s1_go))

	// a blocked last item keeps further items out
	`GFH_ASSERT_NOW(a_blocked_last_holds, clk, arst_n,
		valid_s1 && last_s1 && result.valid && !result.ready, !accept)

	// a modulus write stalls input while the table rebuilds
	`GFH_ASSERT_NEXT(a_cfg_stalls_input, clk, arst_n,
		cfg_wr && reg_idx == gfh_pkg::REG_MODULUS_LOW, !item.ready)

endmodule

FILE: design/gfh_mulred.sv
// Carry-less multiply of two field elements and reduction by a power table.
module gfh_mulred #(
	parameter int FIELD_BITS = gfh_pkg::FIELD_BITS_DEF
) (
	input  logic [FIELD_BITS-1:0] a,
	input  logic [FIELD_BITS-1:0] b,
	input  logic [FIELD_BITS-1:0] tbl [FIELD_BITS-1],
	output logic [FIELD_BITS-1:0] r
);

	localparam int PW = 2 * FIELD_BITS - 1;

	logic [PW-1:0] prod;

	// XOR the shifted partial products
	always_comb begin
		prod = '0;
		for (int i = 0; i < FIELD_BITS; i++) begin
			if (b[i]) begin
				prod = prod ^ (PW'(a) << i);
			end
		end
	end

	// fold each high product bit back through x^(k+j) mod m
	always_comb begin
		r = prod[FIELD_BITS-1:0];
		for (int j = 0; j < FIELD_BITS - 1; j++) begin
			if (prod[FIELD_BITS + j]) begin
				r = r ^ tbl[j];
			end
		end
	end

endmodule

FILE: design/gfh_redtab.sv
// Builds the reduction table x^(k+j) mod m, one entry per cycle.
module gfh_redtab #(
	parameter int FIELD_BITS = gfh_pkg::FIELD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [FIELD_BITS-1:0] low,
	output logic                  busy,
	output logic [FIELD_BITS-1:0] tbl [FIELD_BITS-1]
);

	localparam int TAB_D = FIELD_BITS - 1;
	localparam int CNT_W = $clog2(TAB_D + 1);

	logic                  busy_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [FIELD_BITS-1:0] pow_q;
	logic [FIELD_BITS-1:0] pow_next;
	logic [FIELD_BITS-1:0] tbl_q [TAB_D];

	// multiply the current power by x and reduce
	assign pow_next = {pow_q[FIELD_BITS-2:0], 1'b0} ^ (pow_q[FIELD_BITS-1] ? low : '0);

	// sequence the build
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(TAB_D - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// shift powers into the table, lowest power ends at entry zero
	always_ff @(posedge clk) begin
		if (start) begin
			pow_q <= low;
		end else if (busy_q) begin
			pow_q <= pow_next;
			for (int j = 0; j < TAB_D - 1; j++) begin
				tbl_q[j] <= tbl_q[j + 1];
			end
			tbl_q[TAB_D-1] <= pow_q;
		end
	end

	assign busy = start | busy_q;
	assign tbl  = tbl_q;

endmodule

FILE: dv/tb_top.sv
// Self-checking bench for the GF(2^k) Horner evaluator: directed table, random runs, checker.
`timescale 1ns / 1ps

module tb_top;

	// one directed row: inputs, plus an optional value typed in by hand
	typedef struct packed {
		logic [gfh_pkg::DATA_W-1:0] point;
		logic [gfh_pkg::DATA_W-1:0] coef;
		logic                       first;
		logic                       last;
		logic                       typed;
		logic [gfh_pkg::DATA_W-1:0] want;
	} horner_row_t;

	localparam int DATA_W = gfh_pkg::DATA_W;
	localparam int NUM_ROWS = 20;
	localparam int NUM_PHASES = 4;
	localparam int ITEMS_PER_PHASE = 240;
	localparam int HOLD_AT = 300;
	localparam int HOLD_CYCLES = 150;
	localparam int CALM_FROM = 560;
	localparam int CALM_TO = 720;
	localparam int DRAIN_CYCLES = 4;
	localparam int MAX_PRINTS = 25;

	localparam horner_row_t DIRECTED_ROWS [NUM_ROWS] = '{
		// degree zero: result is the coefficient itself
		'{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 1'b1, 32'h0000_0000},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF},
		// point zero: only the constant coefficient survives
		'{32'h0000_0000, 32'h1234_5678, 1'b1, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0000, 32'hA5A5_A5A5, 1'b0, 1'b1, 1'b1, 32'hA5A5_A5A5},
		// point one: sum of the coefficients
		'{32'h0000_0001, 32'hDEAD_BEEF, 1'b1, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0001, 32'h0F0F_0F0F, 1'b0, 1'b1, 1'b1, 32'hD1A2_B1E0},
		// all-ones operands
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 32'h0},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 32'h0},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 32'h0},
		// top bit set: each step after the first goes through the reduction
		'{32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0, 1'b0, 32'h0},
		'{32'h8000_0000, 32'h0000_0001, 1'b0, 1'b0, 1'b0, 32'h0},
		'{32'h8000_0000, 32'h8000_0001, 1'b0, 1'b1, 1'b0, 32'h0},
		// run without a first mark carries on from the previous value
		'{32'h0000_0003, 32'h0000_00FF, 1'b0, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0003, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, 32'h0},
		// point changes inside one run
		'{32'h1357_9BDF, 32'h0000_0002, 1'b1, 1'b0, 1'b0, 32'h0},
		'{32'hFEDC_BA98, 32'hFFFF_0000, 1'b0, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0002, 32'h0000_FFFF, 1'b0, 1'b1, 1'b0, 32'h0},
		// first mark in the middle of a run restarts it
		'{32'h0000_0002, 32'h0000_0007, 1'b1, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0002, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0002, 32'h0000_0001, 1'b0, 1'b1, 1'b0, 32'h0}
	};

	bit                         clk;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [gfh_pkg::ADDR_W-1:0] paddr;
	logic [DATA_W-1:0]          pwdata;
	logic [DATA_W-1:0]          prdata;
	logic                       pready;

	gfh_in_if  item_if ();
	gfh_out_if result_if ();

	gf2k_horner_polynomial_evaluator_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (item_if),
		.result  (result_if)
	);

	// predictor state and expected polynomial values
	logic [DATA_W-1:0] acc_model;
	logic [DATA_W-1:0] modulus_model;
	logic [DATA_W-1:0] pending_values [$];

	int errors;
	int items_sent;
	int values_checked;
	int hold_left;
	bit hold_done;
	logic calm;

	assign calm = (items_sent >= CALM_FROM) && (items_sent < CALM_TO);

	always #5 clk = ~clk;

	// hard stop
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
		input logic [DATA_W-1:0] want);
		if (errors < MAX_PRINTS)
			$display("%0t: %s: got %08h, want %08h", $realtime, what, got, want);
		errors++;
	endtask

	// a * b in GF(2^32) modulo x^32 + low, MSB first
	function automatic logic [DATA_W-1:0] gf_times(input logic [DATA_W-1:0] a,
		input logic [DATA_W-1:0] b, input logic [DATA_W-1:0] low);
		logic [DATA_W-1:0] r;
		r = '0;
		for (int i = DATA_W - 1; i >= 0; i--) begin
			r = {r[DATA_W-2:0], 1'b0} ^ (r[DATA_W-1] ? low : '0);
			if (b[i])
				r ^= a;
		end
		return r;
	endfunction

	// random field element with a bias toward the extremes
	function automatic logic [DATA_W-1:0] field_elem();
		case ($urandom_range(15))
			0: return '0;
			1: return '1;
			2: return 32'h1 << $urandom_range(DATA_W - 1);
			3: return 32'h8000_0000 | $urandom;
			default: return $urandom;
		endcase
	endfunction

	task automatic read_reg(input gfh_pkg::gfh_reg_t idx, output logic [DATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// write the modulus, then read it back
	task automatic set_modulus(input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] rd;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {gfh_pkg::REG_MODULUS_LOW, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		modulus_model = value;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		read_reg(gfh_pkg::REG_MODULUS_LOW, rd);
		if (rd !== value)
			report_mismatch("modulus readback", rd, value);
	endtask

	// offer one item, hold it until taken, then advance the predictor
	task automatic send_item(input logic [DATA_W-1:0] pt, input logic [DATA_W-1:0] coef,
		input logic first, input logic last, input logic typed, input logic [DATA_W-1:0] want);
		@(negedge clk);
		if (!calm && $urandom_range(99) < 11) begin
			item_if.valid <= 1'b0;
			@(negedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.point <= pt;
		item_if.coefficient <= coef;
		item_if.first_coef <= first;
		item_if.last_coef <= last;
		do @(posedge clk); while (!item_if.ready);
		items_sent++;
		acc_model = gf_times(first ? '0 : acc_model, pt, modulus_model) ^ coef;
		if (last)
			pending_values.push_back(typed ? want : acc_model);
	endtask

	// drop valid and let the block drain before the next register write
	task automatic wait_idle();
		@(negedge clk);
		item_if.valid <= 1'b0;
		while (pending_values.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// result side: random stalls, one long hold-off, a calm stretch
	always @(negedge clk) begin
		if (!hold_done && items_sent >= HOLD_AT) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_if.ready <= 1'b0;
		end else begin
			result_if.ready <= calm || ($urandom_range(99) >= 11);
		end
	end

	// compare each value against the oldest expectation
	always @(posedge clk) begin : value_check
		logic [DATA_W-1:0] want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_values.size() == 0) begin
				report_mismatch("value with none expected", result_if.value, '0);
			end else begin
				want = pending_values.pop_front();
				values_checked++;
				if (result_if.value !== want)
					report_mismatch("polynomial value", result_if.value, want);
			end
		end
	end

	initial begin
		logic [DATA_W-1:0] rd;
		logic [DATA_W-1:0] pt;
		logic              f;
		logic              l;
		int                len;
		int                mode;
		int                quota;
		int                w;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_if.valid = 1'b0;
		item_if.point = '0;
		item_if.coefficient = '0;
		item_if.first_coef = 1'b0;
		item_if.last_coef = 1'b0;
		result_if.ready = 1'b0;
		acc_model = '0;
		modulus_model = gfh_pkg::MODULUS_RESET;

		// reset
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		read_reg(gfh_pkg::REG_MODULUS_LOW, rd);
		if (rd !== gfh_pkg::MODULUS_RESET)
			report_mismatch("modulus after reset", rd, gfh_pkg::MODULUS_RESET);

		// directed table under the reset modulus
		for (int r = 0; r < NUM_ROWS; r++)
			send_item(DIRECTED_ROWS[r].point, DIRECTED_ROWS[r].coef, DIRECTED_ROWS[r].first,
				DIRECTED_ROWS[r].last, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

		// random runs, one modulus per phase
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_idle();
			case (ph)
				0: set_modulus('0);
				1: set_modulus('1);
				2: set_modulus($urandom);
				default: set_modulus(gfh_pkg::MODULUS_RESET);
			endcase
			quota = items_sent + ITEMS_PER_PHASE;
			while (items_sent < quota) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
				mode = $urandom_range(99);
				pt = field_elem();
				for (int k = 0; k < len; k++) begin
					f = (k == 0);
					l = (k == len - 1);
					// missing first mark
					if (mode >= 80 && mode < 86 && k == 0)
						f = 1'b0;
					// run with no end: it merges into the next one
					if (mode >= 86 && mode < 92)
						l = 1'b0;
					// point changes inside the run
					if (mode >= 92 && k > 0 && $urandom_range(2) == 0)
						pt = field_elem();
					// plain noise on the marks
					if (mode >= 97) begin
						f = $urandom_range(1);
						l = $urandom_range(1);
					end
					send_item(pt, field_elem(), f, l, 1'b0, '0);
				end
			end
		end

		// drain, with a limit
		@(negedge clk);
		item_if.valid <= 1'b0;
		for (w = 0; w < 5000 && pending_values.size() != 0; w++)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_values.size() != 0)
			report_mismatch("values never produced", pending_values.size(), '0);

		$display("Run: %0d coefficient items, %0d polynomial values checked,", items_sent,
			values_checked);
		$display("     reset modulus plus %0d written ones incl. zero and all-ones", NUM_PHASES);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
